FILE: design/clfb_pkg.sv
package clfb_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 32;

  localparam int OP_W     = 3;
  localparam int VAL_W    = 8;
  localparam int COL_W    = 6;
  localparam int KIND_W   = 2;
  localparam int STORED_W = 2;
  localparam int FILL_W   = 5;
  localparam int ENTRY_W  = 9;

  // Request operation codes
  localparam logic [OP_W-1:0] OP_CMD     = 3'd0;
  localparam logic [OP_W-1:0] OP_DATA    = 3'd1;
  localparam logic [OP_W-1:0] OP_LOCATE  = 3'd2;
  localparam logic [OP_W-1:0] OP_DECIMAL = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_XFER   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] CURSOR_BASE = 8'h80;

  typedef enum logic [1:0] {
    PUSH_ITEM,
    PUSH_HUND,
    PUSH_TENS,
    PUSH_ONES
  } push_sel_t;

  typedef enum logic [1:0] {
    BUS_NONE,
    BUS_BYTE,
    BUS_HI,
    BUS_LO
  } bus_sel_t;

  typedef struct packed {
    logic              accept;
    logic              push;
    push_sel_t         push_sel;
    logic              pop;
    logic              emit;
    logic [KIND_W-1:0] kind;
    bus_sel_t          bus_sel;
  } clfb_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            four_bit;
    logic            out_free;
  } clfb_stat_t;

  // ASCII decimal digit of an 8-bit number; tens by reciprocal multiply
  function automatic logic [7:0] dec_digit(logic [7:0] v, push_sel_t sel);
    logic [1:0]  h;
    logic [6:0]  rem;
    logic [13:0] prod;
    logic [3:0]  t;
    logic [3:0]  o;
    logic [3:0]  d;
    h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = 7'(v - (8'(h) * 8'd100));
    prod = 14'(rem) * 14'd103;
    t    = prod[13:10];
    o    = 4'(rem - (7'(t) * 7'd10));
    case (sel)
      PUSH_HUND: d = {2'b00, h};
      PUSH_TENS: d = t;
      default:   d = o;
    endcase
    return ASCII_ZERO + {4'b0000, d};
  endfunction

endpackage

FILE: design/clfb_ctrl.sv
module clfb_ctrl
  import clfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  clfb_stat_t stat,
  output clfb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEC1,
    S_DEC2,
    S_STATUS,
    S_EMPTY,
    S_HI,
    S_LO
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_CMD, OP_DATA, OP_LOCATE: begin
            cmd.push     = 1'b1;
            cmd.push_sel = PUSH_ITEM;
            state_nxt    = S_STATUS;
          end
          OP_DECIMAL: begin
            cmd.push     = 1'b1;
            cmd.push_sel = PUSH_HUND;
            state_nxt    = S_DEC1;
          end
          OP_TICK: begin
            if (stat.empty) begin
              state_nxt = S_EMPTY;
            end else begin
              cmd.pop   = 1'b1;
              state_nxt = S_HI;
            end
          end
          default: state_nxt = S_STATUS;
        endcase
      end
      S_DEC1: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_TENS;
        state_nxt    = S_DEC2;
      end
      S_DEC2: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_ONES;
        state_nxt    = S_STATUS;
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_STATUS;
          cmd.bus_sel = BUS_NONE;
          state_nxt   = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_EMPTY;
          cmd.bus_sel = BUS_NONE;
          state_nxt   = S_IDLE;
        end
      end
      S_HI: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_XFER;
          cmd.bus_sel = stat.four_bit ? BUS_HI : BUS_BYTE;
          state_nxt   = stat.four_bit ? S_LO : S_IDLE;
        end
      end
      S_LO: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_XFER;
          cmd.bus_sel = BUS_LO;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/clfb_dp.sv
module clfb_dp
  import clfb_pkg::*;
#(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  clfb_cmd_t           cmd,
  output clfb_stat_t          stat,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [VAL_W-1:0]    in_value,
  input  logic [COL_W-1:0]    in_column,
  input  logic                in_row,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [KIND_W-1:0]   out_kind,
  output logic                out_register_select,
  output logic [VAL_W-1:0]    out_bus_value,
  output logic [STORED_W-1:0] out_entries_stored,
  output logic [FILL_W-1:0]   out_fill_level,
  output logic                out_last
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(FIFO_DEPTH);

  // Request fields held for the duration of the work
  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] val_r;
  logic [COL_W-1:0] col_r;
  logic             row_r;

  logic [AW-1:0]      wr_idx_r, rd_idx_r;
  logic [AW-1:0]      wr_next, rd_next;
  logic [ENTRY_W-1:0] entry_mem_r [FIFO_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] entry;
  logic [6:0]         addr_sum;
  logic               full, empty, do_write;
  logic [STORED_W-1:0] stored_r;
  logic               four_bit_r;

  logic [AW:0]      fill;
  logic [AW+5:0]    fill_ext;

  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic                out_rs_r;
  logic [VAL_W-1:0]    out_bus_r;
  logic [STORED_W-1:0] out_stored_r;
  logic [FILL_W-1:0]   out_fill_r;
  logic                out_last_r;
  logic                out_free;
  logic [VAL_W-1:0]    bus_nxt;

  assign wr_next  = (wr_idx_r == LAST_SLOT) ? '0 : wr_idx_r + 1'b1;
  assign rd_next  = (rd_idx_r == LAST_SLOT) ? '0 : rd_idx_r + 1'b1;
  assign full     = (wr_next == rd_idx_r);
  assign empty    = (wr_idx_r == rd_idx_r);
  assign do_write = cmd.push && !full;

  always_comb begin
    fill = {1'b0, wr_idx_r} - {1'b0, rd_idx_r};
    if (wr_idx_r < rd_idx_r) begin
      fill = fill + DEPTH_EXT;
    end
  end
  assign fill_ext = {5'b00000, fill};

  assign addr_sum = 7'(col_r) + {row_r, 6'b000000};

  always_comb begin
    case (cmd.push_sel)
      PUSH_ITEM: begin
        case (op_r)
          OP_DATA:   entry = {1'b1, val_r};
          OP_LOCATE: entry = {1'b0, CURSOR_BASE | {1'b0, addr_sum}};
          default:   entry = {1'b0, val_r};
        endcase
      end
      default: entry = {1'b1, dec_digit(val_r, cmd.push_sel)};
    endcase
  end

  always_comb begin
    case (cmd.bus_sel)
      BUS_BYTE: bus_nxt = rd_data_r[7:0];
      BUS_HI:   bus_nxt = {4'b0000, rd_data_r[7:4]};
      BUS_LO:   bus_nxt = {4'b0000, rd_data_r[3:0]};
      default:  bus_nxt = '0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  assign stat.op       = op_r;
  assign stat.empty    = empty;
  assign stat.four_bit = four_bit_r;
  assign stat.out_free = out_free;

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      entry_mem_r[wr_next] <= entry;
    end
    if (cmd.pop) begin
      rd_data_r <= entry_mem_r[rd_next];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      val_r <= in_value;
      col_r <= in_column;
      row_r <= in_row;
    end
    if (cmd.accept) begin
      stored_r <= '0;
    end else if (do_write) begin
      stored_r <= stored_r + 1'b1;
    end
    if (cmd.emit) begin
      out_kind_r   <= cmd.kind;
      out_rs_r     <= (cmd.bus_sel != BUS_NONE) ? rd_data_r[8] : 1'b0;
      out_bus_r    <= bus_nxt;
      out_stored_r <= (cmd.kind == KIND_STATUS) ? stored_r : '0;
      out_fill_r   <= fill_ext[4:0];
      out_last_r   <= (cmd.bus_sel != BUS_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      four_bit_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (do_write) begin
        wr_idx_r <= wr_next;
      end
      if (cmd.pop) begin
        rd_idx_r <= rd_next;
      end
      if (cfg_we) begin
        four_bit_r <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_register_select = out_rs_r;
  assign out_bus_value       = out_bus_r;
  assign out_entries_stored  = out_stored_r;
  assign out_fill_level      = out_fill_r;
  assign out_last            = out_last_r;

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !empty)
    else $error("pop issued on empty FIFO");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result loaded over an untaken result");

  a_full_push_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && full) |=> $stable(wr_idx_r))
    else $error("write index moved on push into full FIFO");

  a_stored_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_write && stored_r == 2'd3))
    else $error("stored count overflow");

endmodule

FILE: design/char_lcd_fifo_bus_driver.sv
// A push request registers its fields, writes the FIFO (hundreds, tens and ones for a
// decimal push) and then loads a status result; a tick pops an entry through the
// registered read port and loads the transfer (high, then low nibble if 4-bit), or
// an empty result on an empty FIFO; a new request waits until the last result loads.
// Reset (rst_n low, synchronous): FIFO empty, 4-bit mode, no result pending;
// entry store contents are not cleared.
module char_lcd_fifo_bus_driver
  import clfb_pkg::*;
#(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [VAL_W-1:0]    in_value,
  input  logic [COL_W-1:0]    in_column,
  input  logic                in_row,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KIND_W-1:0]   out_kind,
  output logic                out_register_select,
  output logic [VAL_W-1:0]    out_bus_value,
  output logic [STORED_W-1:0] out_entries_stored,
  output logic [FILL_W-1:0]   out_fill_level,
  output logic                out_last,
  // bus mode register
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  // Controller steps each request through its FIFO writes, pop and result
  // emission; the datapath owns the entry store, indices and output register.
  clfb_cmd_t  cmd;
  clfb_stat_t stat;

  clfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Output register lets the controller take the next request while a
  // finished result still waits on out_stall.
  clfb_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_operation        (in_operation),
    .in_value            (in_value),
    .in_column           (in_column),
    .in_row              (in_row),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_register_select (out_register_select),
    .out_bus_value       (out_bus_value),
    .out_entries_stored  (out_entries_stored),
    .out_fill_level      (out_fill_level),
    .out_last            (out_last)
  );

endmodule
